### rtl/core/tmm_pkg.sv
// tile matrix multiply package: sizes, opcodes and controller/datapath structs
package tmm_pkg;

  localparam int DIM    = 8;
  localparam int IDX_W  = 3;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int OP_W   = 2;
  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = 35;

  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             issue;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] k;
    logic             first;
    logic             last_k;
    logic             last_el;
  } tmm_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } tmm_status_t;

  typedef struct packed {
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    logic             first;
    logic             last_k;
    logic             last_el;
  } tmm_tag_t;

endpackage

### rtl/core/tmm_ram.sv
// generic single write port, single read port ram with registered read
module tmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/tmm_ctrl.sv
// tile matrix multiply controller: load decode and compute sequencing
module tmm_ctrl
  import tmm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [IDX_W-1:0]  row_index_i,
  input  logic [IDX_W-1:0]  col_index_i,
  input  tmm_status_t       status_i,
  output tmm_cmd_t          cmd_o,
  output logic              busy_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
  logic             accept;
  logic             in_range;

  assign busy_o   = (state_q != ST_IDLE);
  assign accept   = start_i && !busy_o;
  assign in_range = ({1'b0, row_index_i} < (IDX_W + 1)'(DIM)) &&
                    ({1'b0, col_index_i} < (IDX_W + 1)'(DIM));

  always_comb begin
    state_d       = state_q;
    r_d           = r_q;
    c_d           = c_q;
    k_d           = k_q;
    cmd_o         = '0;
    cmd_o.r       = r_q;
    cmd_o.c       = c_q;
    cmd_o.k       = k_q;
    cmd_o.first   = (k_q == '0);
    cmd_o.last_k  = (k_q == IDX_LAST);
    cmd_o.last_el = (r_q == IDX_LAST) && (c_q == IDX_LAST);
    case (state_q)
      ST_IDLE: begin
        r_d = '0;
        c_d = '0;
        k_d = '0;
        if (accept) begin
          case (opcode_i)
            OP_LOAD_A:  cmd_o.wr_a = in_range;
            OP_LOAD_B:  cmd_o.wr_b = in_range;
            OP_COMPUTE: state_d = ST_RUN;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (k_q != IDX_LAST) begin
          k_d = k_q + 1'b1;
        end else begin
          k_d = '0;
          if (c_q != IDX_LAST) begin
            c_d = c_q + 1'b1;
          end else begin
            c_d = '0;
            if (r_q != IDX_LAST) begin
              r_d = r_q + 1'b1;
            end else begin
              r_d     = '0;
              state_d = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
    end
  end

`ifndef SYNTHESIS
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_a || cmd_o.wr_b) |-> (state_q == ST_IDLE && start_i))
    else $error("store write outside idle");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.issue && cmd_o.last_el && cmd_o.last_k) |=> (state_q == ST_DRAIN))
    else $error("compute did not end after final product term");

  a_drain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && !status_i.pipe_busy) |=> !busy_o)
    else $error("drain did not return to idle");
`endif

endmodule

### rtl/core/tmm_dp.sv
// tile matrix multiply datapath: a and b stores, multiplier and accumulator
module tmm_dp
  import tmm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tmm_cmd_t                cmd_i,
  input  logic [IDX_W-1:0]        row_index_i,
  input  logic [IDX_W-1:0]        col_index_i,
  input  logic signed [ELEM_W-1:0] element_value_i,
  output tmm_status_t             status_o,
  output logic                    out_valid_o,
  output logic [IDX_W-1:0]        out_row_o,
  output logic [IDX_W-1:0]        out_col_o,
  output logic signed [ACC_W-1:0] product_value_o,
  output logic                    last_o
);

  logic [ADDR_W-1:0]        waddr;
  logic [ELEM_W-1:0]        a_raw, b_raw;
  logic signed [ELEM_W-1:0] a_rd, b_rd;
  logic                     v1_q, v2_q, out_valid_q;
  tmm_tag_t                 tag0, tag1_q, tag2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d, acc_base, prod_ext;
  logic [IDX_W-1:0]         out_row_q, out_col_q;
  logic                     out_last_q;
  logic signed [ACC_W-1:0]  out_val_q;

  assign waddr = {row_index_i, col_index_i};

  tmm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_a),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .re_i    (cmd_i.issue),
    .raddr_i ({cmd_i.r, cmd_i.k}),
    .rdata_o (a_raw)
  );

  tmm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_b),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .re_i    (cmd_i.issue),
    .raddr_i ({cmd_i.k, cmd_i.c}),
    .rdata_o (b_raw)
  );

  assign a_rd = a_raw;
  assign b_rd = b_raw;

  assign tag0.r       = cmd_i.r;
  assign tag0.c       = cmd_i.c;
  assign tag0.first   = cmd_i.first;
  assign tag0.last_k  = cmd_i.last_k;
  assign tag0.last_el = cmd_i.last_el;

  assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign acc_base = tag2_q.first ? '0 : acc_q;
  assign acc_d    = acc_base + prod_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q        <= cmd_i.issue;
      v2_q        <= v1_q;
      out_valid_q <= v2_q && tag2_q.last_k;
    end
  end

  always_ff @(posedge clk_i) begin
    tag1_q <= tag0;
    tag2_q <= tag1_q;
    prod_q <= a_rd * b_rd;
    if (v2_q) begin
      acc_q <= acc_d;
    end
    if (v2_q && tag2_q.last_k) begin
      out_row_q  <= tag2_q.r;
      out_col_q  <= tag2_q.c;
      out_last_q <= tag2_q.last_el;
      out_val_q  <= acc_d;
    end
  end

  assign status_o.pipe_busy = v1_q || v2_q;
  assign out_valid_o        = out_valid_q;
  assign out_row_o          = out_row_q;
  assign out_col_o          = out_col_q;
  assign product_value_o    = out_val_q;
  assign last_o             = out_last_q;

`ifndef SYNTHESIS
  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $past(v2_q && tag2_q.last_k))
    else $error("result strobe without a finished dot product");

  a_last_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |=> !out_valid_q)
    else $error("result strobe right after final item");
`endif

endmodule

### rtl/core/tile_matrix_multiply_unit.sv
// tile matrix multiply top level: controller and datapath
//
// channel   ports                                              handshake
// command   opcode_i row_index_i col_index_i element_value_i   start && !busy
// result    out_row_o out_col_o product_value_o last_o         out_valid_o, one cycle
//
// a load is written into its store when accepted and busy stays low
// a compute holds busy until the pipeline drains: one multiply-accumulate per cycle,
// fed by one read port on each of the a and b stores, then the pipeline drain
// one result comes out per dot product, the final one in the last cycle of busy
// no clearing pass after reset; the receiver cannot stall and results are never held
module tile_matrix_multiply_unit
  import tmm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic [IDX_W-1:0]         row_index_i,
  input  logic [IDX_W-1:0]         col_index_i,
  input  logic signed [ELEM_W-1:0] element_value_i,
  output logic                     out_valid_o,
  output logic [IDX_W-1:0]         out_row_o,
  output logic [IDX_W-1:0]         out_col_o,
  output logic signed [ACC_W-1:0]  product_value_o,
  output logic                     last_o
);

  tmm_cmd_t    cmd;
  tmm_status_t status;

  tmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .opcode_i    (opcode_i),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  tmm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .product_value_o (product_value_o),
    .last_o          (last_o)
  );

endmodule

### tb/tile_matrix_multiply_unit_tb.sv
// self-checking testbench for the tile matrix multiply unit: loads, ignored items and computes
`timescale 1ns / 100ps

module tile_matrix_multiply_unit_tb;
  import tmm_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int MAX_GAP        = 64;
  localparam int END_SETTLE     = 4 * DIM;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [ACC_W-1:0] value;
    logic                    last;
  } product_elem_t;

  class product_scoreboard;
    logic signed [ELEM_W-1:0] a_tile [DEPTH];
    logic signed [ELEM_W-1:0] b_tile [DEPTH];
    product_elem_t            pending_q [$];
    int errors;
    int loads;
    int computes;
    int ignored;
    int checked;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        a_tile[i] = '0;
        b_tile[i] = '0;
      end
      errors   = 0;
      loads    = 0;
      computes = 0;
      ignored  = 0;
      checked  = 0;
    endfunction

    function void note_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col,
                            input logic signed [ELEM_W-1:0] val);
      product_elem_t           elem;
      logic signed [ACC_W-1:0] acc;
      logic signed [ELEM_W-1:0] a_el;
      logic signed [ELEM_W-1:0] b_el;
      if (op == OP_LOAD_A || op == OP_LOAD_B) begin
        if (int'(row) < DIM && int'(col) < DIM) begin
          if (op == OP_LOAD_A) begin
            a_tile[{row, col}] = val;
          end else begin
            b_tile[{row, col}] = val;
          end
        end
        loads++;
      end else if (op == OP_COMPUTE) begin
        for (int r = 0; r < DIM; r++) begin
          for (int c = 0; c < DIM; c++) begin
            acc = '0;
            for (int k = 0; k < DIM; k++) begin
              a_el = a_tile[(r << IDX_W) + k];
              b_el = b_tile[(k << IDX_W) + c];
              acc  = acc + a_el * b_el;
            end
            elem.row   = IDX_W'(r);
            elem.col   = IDX_W'(c);
            elem.value = acc;
            elem.last  = (r == DIM - 1) && (c == DIM - 1);
            pending_q.push_back(elem);
          end
        end
        computes++;
      end else begin
        ignored++;
      end
    endfunction

    function void check_result(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                               input logic signed [ACC_W-1:0] value, input logic last);
      product_elem_t elem;
      if (pending_q.size() == 0) begin
        $error("unexpected product element: row %0d col %0d value %0d last %0b",
               row, col, value, last);
        errors++;
      end else begin
        elem = pending_q.pop_front();
        checked++;
        if (row !== elem.row) begin
          $error("out_row mismatch: expected %0d, actual %0d", elem.row, row);
          errors++;
        end
        if (col !== elem.col) begin
          $error("out_col mismatch: expected %0d, actual %0d", elem.col, col);
          errors++;
        end
        if (value !== elem.value) begin
          $error("product_value mismatch: expected %0d, actual %0d", elem.value, value);
          errors++;
        end
        if (last !== elem.last) begin
          $error("last mismatch: expected %0b, actual %0b", elem.last, last);
          errors++;
        end
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [OP_W-1:0]          opcode_i;
  logic [IDX_W-1:0]         row_index_i;
  logic [IDX_W-1:0]         col_index_i;
  logic signed [ELEM_W-1:0] element_value_i;
  logic                     out_valid_o;
  logic [IDX_W-1:0]         out_row_o;
  logic [IDX_W-1:0]         out_col_o;
  logic signed [ACC_W-1:0]  product_value_o;
  logic                     last_o;

  product_scoreboard sb = new();
  int idle_pct;
  int quiet_cycles;

  tile_matrix_multiply_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .product_value_o (product_value_o),
    .last_o          (last_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      sb.check_result(out_row_o, out_col_o, product_value_o, last_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || out_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles with nothing accepted", quiet_cycles);
      $display("tile_matrix_multiply_unit_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic signed [ELEM_W-1:0] val);
    int gap;
    gap = 0;
    while (idle_pct != 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start           <= 1'b0;
      opcode_i        <= OP_W'($urandom);
      row_index_i     <= IDX_W'($urandom);
      col_index_i     <= IDX_W'($urandom);
      element_value_i <= ELEM_W'($urandom);
      gap++;
    end
    @(negedge clk_i);
    start           <= 1'b1;
    opcode_i        <= op;
    row_index_i     <= row;
    col_index_i     <= col;
    element_value_i <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(op, row, col, val);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic fill_tile(input logic [OP_W-1:0] op, input logic signed [ELEM_W-1:0] val);
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        send_item(op, IDX_W'(r), IDX_W'(c), val);
      end
    end
  endtask

  task automatic run_random(input int pct, input int n_items);
    int sent;
    int pick;
    logic [OP_W-1:0] op;
    logic signed [ELEM_W-1:0] val;
    idle_pct = pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      case ($urandom_range(7))
        0:       val = 16'sh8000;
        1:       val = 16'sh7fff;
        2:       val = '0;
        3:       val = '1;
        default: val = ELEM_W'($urandom);
      endcase
      if (pick < 8) begin
        send_item(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), val);
      end else begin
        if (pick < 18) begin
          op = OP_COMPUTE;
        end else begin
          op = $urandom_range(1) ? OP_LOAD_B : OP_LOAD_A;
        end
        send_item(op, IDX_W'($urandom), IDX_W'($urandom), val);
        sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    opcode_i        = OP_LOAD_A;
    row_index_i     = '0;
    col_index_i     = '0;
    element_value_i = '0;
    idle_pct        = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // most negative sums everywhere, then largest positive sums in column zero
    fill_tile(OP_LOAD_A, 16'sh8000);
    fill_tile(OP_LOAD_B, 16'sh7fff);
    send_item(OP_COMPUTE, '0, '0, '0);
    for (int k = 0; k < DIM; k++) begin
      send_item(OP_LOAD_B, IDX_W'(k), '0, 16'sh8000);
    end
    send_item(OP_COMPUTE, '1, '1, '1);

    send_item(OP_LOAD_A, 3'd0, 3'd0, 16'sh7fff);
    send_item(OP_LOAD_A, 3'd7, 3'd7, 16'sh0000);
    send_item(OP_LOAD_A, 3'd3, 3'd4, 16'shffff);
    send_item(OP_LOAD_B, 3'd0, 3'd7, 16'sh8000);
    send_item(OP_LOAD_B, 3'd7, 3'd0, 16'sh0001);
    send_item(OP_LOAD_B, 3'd5, 3'd2, 16'sh0100);
    send_item(OP_UNUSED, 3'd7, 3'd7, 16'shffff);
    send_item(OP_COMPUTE, 3'd5, 3'd2, 16'sh1234);
    send_item(OP_COMPUTE, 3'd0, 3'd0, 16'sh0000);
    send_item(OP_LOAD_A, 3'd7, 3'd0, 16'sh5555);
    send_item(OP_LOAD_B, 3'd0, 3'd0, 16'shaaaa);
    send_item(OP_UNUSED, 3'd0, 3'd0, 16'sh0000);
    send_item(OP_COMPUTE, 3'd7, 3'd7, 16'sh7fff);
    wait_drained();

    run_random(86, 6);
    run_random(25, 6);
    run_random(0, 6);

    repeat (END_SETTLE) @(posedge clk_i);
    $display("run covered %0d loads, %0d computes and %0d ignored items",
             sb.loads, sb.computes, sb.ignored);
    $display("checked %0d product elements with %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tile_matrix_multiply_unit_tb OK");
    end else begin
      if (sb.pending_q.size() != 0) begin
        $error("%0d product elements never arrived", sb.pending_q.size());
      end
      $display("tile_matrix_multiply_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
